// ===== hw/rtl/facr_pkg.sv =====
// Shared types and constants for the fully associative cache replacement core.
package facr_pkg;

   // Fixed widths of the channel payloads
   localparam int ADDR_W     = 32;
   localparam int COUNT_W    = 32;
   localparam int CAP_W      = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 2'd1;

   // Replacement policy codes
   typedef enum logic {
      POLICY_FIFO = 1'b0,
      POLICY_LRU  = 1'b1
   } policy_type;

   // Reset values of the registers
   localparam policy_type           POLICY_RESET   = POLICY_LRU;
   localparam logic [CAP_W-1:0]     CAPACITY_RESET = 5'd16;
   localparam logic [COUNT_W-1:0]   COUNT_MAX      = '1;

   // Control from the top level to the entry store for one word
   typedef struct packed {
      logic update;    // commit this word to the store
      logic lru_mode;  // move a hit entry to the newest end
      logic full;      // store holds the effective capacity
   } store_ctrl_type;

endpackage

// ===== hw/rtl/facr_if.sv =====
// Channel interfaces: lookup request, lookup response and register write.
interface facr_req_if;
   import facr_pkg::*;
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] block_address;
   modport source (output valid, output block_address, input ready);
   modport sink   (input valid, input block_address, output ready);
endinterface

interface facr_rsp_if;
   import facr_pkg::*;
   logic               valid;
   logic               ready;
   logic               hit;
   logic               evicted;
   logic [ADDR_W-1:0]  evicted_address;
   logic [COUNT_W-1:0] access_count;
   logic [COUNT_W-1:0] miss_count;
   modport source (output valid, output hit, output evicted, output evicted_address,
                   output access_count, output miss_count, input ready);
   modport sink   (input valid, input hit, input evicted, input evicted_address,
                   input access_count, input miss_count, output ready);
endinterface

interface facr_csr_if;
   import facr_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/facr_store.sv =====
// Age-ordered entry store with parallel match and shift update.
module facr_store #(
   parameter int ENTRIES = 16,
   parameter int KEEP_W  = 32,
   parameter int FILL_W  = 5
) (
   input  logic                     clock,
   input  facr_pkg::store_ctrl_type ctrl,
   input  logic [FILL_W-1:0]        fill_level,
   input  logic [KEEP_W-1:0]        lookup_addr,
   output logic                     hit,
   output logic [KEEP_W-1:0]        oldest
);
   import facr_pkg::*;

   logic [KEEP_W-1:0] entries_ff [ENTRIES];
   logic [KEEP_W-1:0] entries_in [ENTRIES];
   logic [ENTRIES-1:0] match;
   logic [ENTRIES-1:0] at_or_after;
   logic               do_shift;
   logic [FILL_W-1:0]  last_slot;

   assign last_slot = fill_level - FILL_W'(1);
   assign hit       = |match;
   assign oldest    = entries_ff[0];
   // Shift on an LRU hit (from the hit slot) or on a miss into a full store (from slot 0)
   assign do_shift  = hit ? ctrl.lru_mode : ctrl.full;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_slot
      logic [KEEP_W-1:0] next_val;

      assign match[i] = (FILL_W'(i) < fill_level) && (entries_ff[i] == lookup_addr);

      if (i == 0) begin : g_first
         assign at_or_after[i] = match[i];
      end else begin : g_rest
         assign at_or_after[i] = at_or_after[i-1] | match[i];
      end

      if (i == ENTRIES - 1) begin : g_tail
         assign next_val = entries_ff[i];
      end else begin : g_body
         assign next_val = entries_ff[i+1];
      end

      always_comb begin
         entries_in[i] = entries_ff[i];
         if (do_shift) begin
            if (FILL_W'(i) == last_slot) begin
               entries_in[i] = lookup_addr;
            end else if ((FILL_W'(i) < last_slot) && (!hit || at_or_after[i])) begin
               entries_in[i] = next_val;
            end
         end else if (!hit && (FILL_W'(i) == fill_level)) begin
            entries_in[i] = lookup_addr;
         end
      end

      always_ff @(posedge clock) begin
         if (ctrl.update) begin
            entries_ff[i] <= entries_in[i];
         end
      end
   end

endmodule

// ===== hw/rtl/fully_assoc_cache_replacement_core.sv =====
// Top level of the fully associative cache replacement core.
// Each request word carries one block address; the core looks it up among up
// to ENTRIES stored addresses kept oldest-first, applies FIFO or LRU
// replacement, and returns one response word with hit, eviction and saturating
// access and miss totals. Throughput is one word per cycle: the whole lookup
// (parallel compare over all ENTRIES slots plus the shift update of the store)
// sits between the request register and the response register, so the
// response word is registered as the request word advances, and a
// stalled response holds the request register and with it the request side.
// Entries need no clearing pass: only slots below the fill level are ever
// compared. Write the registers only while the core is idle; the register
// port always accepts.
module fully_assoc_cache_replacement_core #(
   parameter int ENTRIES   = 16,
   parameter int ADDR_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   facr_req_if.sink   req_if,
   facr_rsp_if.source rsp_if,
   facr_csr_if.sink   csr_if
);
   import facr_pkg::*;

   // Stored address bits: masked to ADDR_BITS, never wider than the port
   localparam int KEEP_W = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
   localparam int FILL_W = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;

   // Configuration registers
   policy_type         policy_ff, policy_in;
   logic [CAP_W-1:0]   capacity_ff, capacity_in;

   // Request register
   logic               req_vld_ff, req_vld_in;
   logic [KEEP_W-1:0]  req_addr_ff, req_addr_in;

   // Core state and response register
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [COUNT_W-1:0] access_ff, access_in;
   logic [COUNT_W-1:0] miss_ff, miss_in;
   logic               rsp_vld_ff, rsp_vld_in;
   logic               hit_ff, hit_in;
   logic               evicted_ff, evicted_in;
   logic [KEEP_W-1:0]  ev_addr_ff, ev_addr_in;

   logic               advance;
   logic [CMP_W-1:0]   cap_raw;
   logic [CMP_W-1:0]   cap_eff;
   logic               full;
   logic               hit;
   logic [KEEP_W-1:0]  oldest;
   store_ctrl_type     ctrl;

   // Advance the request word into the response register when that is free
   assign advance       = req_vld_ff && (!rsp_vld_ff || rsp_if.ready);
   assign req_if.ready  = !req_vld_ff || advance;
   assign csr_if.ready  = 1'b1;

   // Clamp capacity into 1..ENTRIES
   assign cap_raw = CMP_W'(capacity_ff);
   always_comb begin
      cap_eff = cap_raw;
      if (cap_raw == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_raw > CMP_W'(ENTRIES)) begin
         cap_eff = CMP_W'(ENTRIES);
      end
   end
   assign full = CMP_W'(fill_ff) >= cap_eff;

   assign ctrl.update   = advance;
   assign ctrl.lru_mode = (policy_ff == POLICY_LRU);
   assign ctrl.full     = full;

   facr_store #(
      .ENTRIES (ENTRIES),
      .KEEP_W  (KEEP_W),
      .FILL_W  (FILL_W)
   ) u_store (
      .clock       (clock),
      .ctrl        (ctrl),
      .fill_level  (fill_ff),
      .lookup_addr (req_addr_ff),
      .hit         (hit),
      .oldest      (oldest)
   );

   // Register writes; drop unknown indexes
   always_comb begin
      policy_in   = policy_ff;
      capacity_in = capacity_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            CSR_POLICY:   policy_in   = policy_type'(csr_if.data[0]);
            CSR_CAPACITY: capacity_in = csr_if.data[CAP_W-1:0];
            default:      ;
         endcase
      end
   end

   // Request register: load on acceptance, clear when drained
   always_comb begin
      req_vld_in  = req_vld_ff;
      req_addr_in = req_addr_ff;
      if (req_if.valid && req_if.ready) begin
         req_vld_in  = 1'b1;
         req_addr_in = req_if.block_address[KEEP_W-1:0];
      end else if (advance) begin
         req_vld_in  = 1'b0;
      end
   end

   // Lookup result, totals and fill level
   always_comb begin
      fill_in    = fill_ff;
      access_in  = access_ff;
      miss_in    = miss_ff;
      hit_in     = hit_ff;
      evicted_in = evicted_ff;
      ev_addr_in = ev_addr_ff;
      rsp_vld_in = rsp_vld_ff;
      if (rsp_vld_ff && rsp_if.ready) begin
         rsp_vld_in = 1'b0;
      end
      if (advance) begin
         rsp_vld_in = 1'b1;
         hit_in     = hit;
         evicted_in = !hit && full;
         ev_addr_in = (!hit && full) ? oldest : '0;
         if (access_ff != COUNT_MAX) begin
            access_in = access_ff + COUNT_W'(1);
         end
         if (!hit) begin
            if (miss_ff != COUNT_MAX) begin
               miss_in = miss_ff + COUNT_W'(1);
            end
            if (!full) begin
               fill_in = fill_ff + FILL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff   <= POLICY_RESET;
         capacity_ff <= CAPACITY_RESET;
         req_vld_ff  <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         fill_ff     <= '0;
         access_ff   <= '0;
         miss_ff     <= '0;
      end else begin
         policy_ff   <= policy_in;
         capacity_ff <= capacity_in;
         req_vld_ff  <= req_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         fill_ff     <= fill_in;
         access_ff   <= access_in;
         miss_ff     <= miss_in;
      end
   end

   always_ff @(posedge clock) begin
      req_addr_ff <= req_addr_in;
      hit_ff      <= hit_in;
      evicted_ff  <= evicted_in;
      ev_addr_ff  <= ev_addr_in;
   end

   assign rsp_if.valid           = rsp_vld_ff;
   assign rsp_if.hit             = hit_ff;
   assign rsp_if.evicted         = evicted_ff;
   assign rsp_if.evicted_address = ADDR_W'(ev_addr_ff);
   assign rsp_if.access_count    = access_ff;
   assign rsp_if.miss_count      = miss_ff;

   // A hit never evicts
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> !(hit_ff && evicted_ff))
      else $error("hit reported together with eviction");

   // Misses never outnumber accesses
   a_miss_le_access: assert property (@(posedge clock) disable iff (reset)
      miss_ff <= access_ff)
      else $error("miss total exceeds access total");

   // Fill level stays within the store
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(fill_ff) <= CMP_W'(ENTRIES))
      else $error("fill level beyond store depth");

   // A miss into a store that is not full appends without eviction
   a_append_no_evict: assert property (@(posedge clock) disable iff (reset)
      (advance && !hit && !full) |=> (rsp_vld_ff && !evicted_ff && fill_ff != '0))
      else $error("append reported an eviction");

endmodule

// ===== bench/fully_assoc_cache_replacement_core_tb.sv =====
// Self-checking testbench for the fully associative cache replacement core.
`timescale 1ns / 1ps

module fully_assoc_cache_replacement_core_tb;
   import facr_pkg::*;

   localparam int DEPTH         = 16;     // ENTRIES of the instance under test
   localparam int PHASES        = 12;     // random phases after the directed part
   localparam int PHASE_WORDS   = 115;    // lookup words per random phase
   localparam int IDLE_LIMIT    = 2000;   // cycles without any handshake before giving up
   localparam int SETTLE_CYCLES = 8;      // quiet time after the last response

   // Indexes the core does not decode; writes there must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   typedef struct packed {
      logic               hit;
      logic               evicted;
      logic [ADDR_W-1:0]  evicted_address;
      logic [COUNT_W-1:0] access_count;
      logic [COUNT_W-1:0] miss_count;
   } lookup_result_type;

   // Tracks the cache contents oldest-first and queues the response due for
   // each accepted lookup word.
   class cache_scoreboard;
      logic [ADDR_W-1:0]  lines[$];
      policy_type         policy;
      logic [CAP_W-1:0]   capacity;
      logic [COUNT_W-1:0] access_total;
      logic [COUNT_W-1:0] miss_total;
      lookup_result_type  due[$];
      int                 errors;
      int                 lookups;
      int                 hits;
      int                 evictions;
      int                 settings;

      function new();
         policy       = POLICY_RESET;
         capacity     = CAPACITY_RESET;
         access_total = '0;
         miss_total   = '0;
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         settings++;
         case (index)
            CSR_POLICY:   policy = policy_type'(data[0]);
            CSR_CAPACITY: capacity = data[CAP_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned effective_capacity();
         if (capacity == 0)
            return 1;
         if (capacity > DEPTH)
            return DEPTH;
         return 32'(capacity);
      endfunction

      // Apply one lookup to the cache image and queue its response.
      function void note_lookup(logic [ADDR_W-1:0] addr);
         lookup_result_type r;
         int                slot;
         r    = '0;
         slot = -1;
         if (access_total != COUNT_MAX)
            access_total++;
         foreach (lines[i]) begin
            if (slot < 0 && lines[i] == addr)
               slot = i;
         end
         if (slot >= 0) begin
            r.hit = 1'b1;
            if (policy == POLICY_LRU) begin
               lines.delete(slot);
               lines.insert(lines.size(), addr);
            end
         end else begin
            if (miss_total != COUNT_MAX)
               miss_total++;
            // Fill level never shrinks, even when capacity drops below it
            if (lines.size() >= effective_capacity()) begin
               r.evicted         = 1'b1;
               r.evicted_address = lines.pop_front();
            end
            lines.insert(lines.size(), addr);
         end
         r.access_count = access_total;
         r.miss_count   = miss_total;
         due.insert(due.size(), r);
      endfunction

      function void check_response(lookup_result_type got);
         lookup_result_type want;
         string             bad;
         if (due.size() == 0) begin
            flag($sformatf("response with nothing pending: %p", got));
            return;
         end
         want = due.pop_front();
         lookups++;
         if (want.hit)
            hits++;
         if (want.evicted)
            evictions++;
         bad = "";
         if (got.hit !== want.hit)
            bad = {bad, " hit"};
         if (got.evicted !== want.evicted)
            bad = {bad, " evicted"};
         if (got.evicted_address !== want.evicted_address)
            bad = {bad, " evicted_address"};
         if (got.access_count !== want.access_count)
            bad = {bad, " access_count"};
         if (got.miss_count !== want.miss_count)
            bad = {bad, " miss_count"};
         if (bad != "")
            flag($sformatf("response %0d mismatch in%s: expected %p, got %p",
                           lookups, bad, want, got));
      endfunction

      function int pending();
         return due.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   facr_req_if req_if ();
   facr_rsp_if rsp_if ();
   facr_csr_if csr_if ();

   fully_assoc_cache_replacement_core #(
      .ENTRIES   (DEPTH),
      .ADDR_BITS (ADDR_W)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   cache_scoreboard   sb = new();
   logic [ADDR_W-1:0] addr_pool[$];
   int                idle_cycles;
   int                gap_odds;     // 0: sender never pauses, else 1-in-N chance per word
   bit                steady;       // set for the closing stretch: no pauses on either side
   policy_type        plan_policy[PHASES];
   int                plan_cap[PHASES];

   // 2 ns clock
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Sample every channel at the rising edge. Check the response before
   // noting a new lookup; the core's latency keeps the two apart anyway.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready)
            sb.check_response('{rsp_if.hit, rsp_if.evicted, rsp_if.evicted_address,
                                rsp_if.access_count, rsp_if.miss_count});
         if (req_if.valid && req_if.ready)
            sb.note_lookup(req_if.block_address);
         if (csr_if.valid && csr_if.ready)
            sb.write_reg(csr_if.index, csr_if.data);
      end
   end

   // Watchdog: give up after a long run of cycles with no handshake at all.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("ERROR: no handshake for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Response side back-pressure: each stretch is, at random, either calm or
   // a stretch of random stall bursts that drop ready.
   initial begin
      int stretch;
      int odds;
      rsp_if.ready = 1'b0;
      forever begin
         stretch = $urandom_range(20, 80);
         odds    = $urandom_range(0, 2) * 4;
         repeat (stretch) begin
            @(negedge clock);
            if (!steady && odds != 0 && $urandom_range(0, odds - 1) == 0) begin
               rsp_if.ready <= 1'b0;
               repeat ($urandom_range(1, 11)) @(negedge clock);
            end
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Present one lookup word and hold it until accepted. Valid stays high
   // on return so back-to-back words need no extra edge on it.
   task automatic send_lookup(logic [ADDR_W-1:0] addr);
      if (!steady && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.block_address <= addr;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // Reprogram the core once it has gone idle. Upper data bits carry junk,
   // and now and then an undecoded index is written as well.
   task automatic configure(policy_type pol, logic [CAP_W-1:0] cap);
      logic [CSR_DATA_W-1:0] data;
      req_if.valid <= 1'b0;
      wait_drained();
      data    = $urandom();
      data[0] = pol;
      write_csr(CSR_POLICY, data);
      data              = $urandom();
      data[CAP_W-1:0]   = cap;
      write_csr(CSR_CAPACITY, data);
      if ($urandom_range(0, 2) == 0)
         write_csr($urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO, $urandom());
      csr_if.valid <= 1'b0;
   endtask

   // Mostly reuse a working set from the capacity up to four above it, so hits,
   // LRU reordering and evictions all happen; mix in fresh and extreme words.
   function automatic logic [ADDR_W-1:0] pick_address();
      int r;
      r = $urandom_range(0, 99);
      if (r < 82)
         return addr_pool[$urandom_range(0, addr_pool.size() - 1)];
      if (r < 96)
         return $urandom();
      return (r < 98) ? '0 : '1;
   endfunction

   task automatic run_phase(int idx);
      int set_size;
      configure(plan_policy[idx], CAP_W'(plan_cap[idx]));
      gap_odds = (idx % 3 == 0) ? 0 : ((idx % 3 == 1) ? 4 : 10);
      steady   = (idx == PHASES - 1);
      set_size = int'(sb.effective_capacity() + $urandom_range(0, 4));
      if (set_size < 2)
         set_size = 2;
      addr_pool.delete();
      repeat (set_size) addr_pool.insert(addr_pool.size(), $urandom());
      repeat (PHASE_WORDS) send_lookup(pick_address());
      req_if.valid <= 1'b0;
   endtask

   initial begin
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.block_address = '0;
      csr_if.valid         = 1'b0;
      csr_if.index         = CSR_POLICY;
      csr_if.data          = '0;
      gap_odds             = 0;
      steady               = 1'b0;

      // Phase plan: capacity grows while the store fills, one phase drops it
      // below the fill level, then the out-of-range values and random picks.
      plan_policy[0] = POLICY_FIFO;  plan_cap[0] = 3;
      plan_policy[1] = POLICY_LRU;   plan_cap[1] = 6;
      plan_policy[2] = POLICY_LRU;   plan_cap[2] = 4;
      plan_policy[3] = POLICY_FIFO;  plan_cap[3] = 9;
      plan_policy[4] = POLICY_LRU;   plan_cap[4] = 12;
      plan_policy[5] = POLICY_FIFO;  plan_cap[5] = 31;
      plan_policy[6] = POLICY_LRU;   plan_cap[6] = 17;
      plan_policy[7] = POLICY_FIFO;  plan_cap[7] = 16;
      for (int i = 8; i < PHASES; i++) begin
         plan_policy[i] = policy_type'($urandom_range(0, 1));
         plan_cap[i]    = $urandom_range(0, 31);
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Capacity zero on an empty store must behave as one entry
      configure(POLICY_FIFO, 5'd0);
      send_lookup('0);
      send_lookup('0);
      send_lookup('1);
      // Two entries under LRU: a hit moves the entry to the newest end
      configure(POLICY_LRU, 5'd2);
      send_lookup(32'hA5A5_A5A5);
      send_lookup('1);
      send_lookup(32'h5A5A_5A5A);
      send_lookup('1);
      // Capacity one below a fill level of two: evict the oldest, keep the level
      configure(POLICY_FIFO, 5'd1);
      send_lookup('0);
      send_lookup(32'h5A5A_5A5A);
      send_lookup('0);
      send_lookup(32'h8000_0001);
      send_lookup('0);

      for (int p = 0; p < PHASES; p++)
         run_phase(p);

      // Wait out the pipeline, then let a stray response show up if one exists
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (sb.pending() != 0)
         sb.flag($sformatf("%0d responses never arrived", sb.pending()));

      $display("Covered %0d lookups (%0d hits, %0d evictions) over %0d register writes,",
               sb.lookups, sb.hits, sb.evictions, sb.settings);
      $display("FIFO and LRU, capacities 0 to 31 incl. one below the fill level.");
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
